/* sv/sample_log_ring_with_timebase_defines.svh */
// ---------------------------------------------------------------------------
// Sample log ring assertion macros
// Shared concurrent assertion forms for the sample log ring checkers.
// ---------------------------------------------------------------------------
`ifndef SAMPLE_LOG_RING_WITH_TIMEBASE_DEFINES_SVH
`define SAMPLE_LOG_RING_WITH_TIMEBASE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLRT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sample log ring: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SLRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sample log ring: next-cycle check failed");

`endif

/* sv/slrt_pkg.sv */
// ---------------------------------------------------------------------------
// Sample log ring package
// Sizes, command codes, item types and the slot arithmetic of the log ring.
// ---------------------------------------------------------------------------
package slrt_pkg;

   // Ring geometry, fixed by the widths of the item fields.
   localparam int SLOTS   = 64;
   localparam int SLOT_W  = 6;
   localparam int COUNT_W = 7;

   // Default number of low time bits cleared in the base.
   localparam int BASE_SHIFT_DEFAULT = 16;

   // Reset value of the timestamp type code register.
   localparam logic [7:0] TS_CODE_RESET = 8'd7;

   // Command codes.
   localparam logic [1:0] CMD_STORE = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_READ_DATA,
      ST_WALK,
      ST_DONE
   } state_type;

   // One input item.
   typedef struct packed {
      logic [1:0]          command;
      logic [7:0]          sensor_type;
      logic signed [31:0]  reading_value;
      logic [6:0]          clear_count;
      logic [5:0]          read_index;
      logic [63:0]         now_ms;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [6:0]          entry_count;
      logic [5:0]          oldest_slot;
      logic [63:0]         base_ms;
      logic                read_valid;
      logic [7:0]          read_type;
      logic signed [31:0]  read_value;
      logic [63:0]         read_time_ms;
   } rsp_type;

   // Slot index a positions after slot s, wrapping round the ring.
   function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] s,
                                                  input logic [SLOT_W-1:0] a);
      logic [SLOT_W:0] sum;
      sum = {1'b0, s} + {1'b0, a};
      if (sum >= (SLOT_W+1)'(SLOTS)) begin
         sum = sum - (SLOT_W+1)'(SLOTS);
      end
      return sum[SLOT_W-1:0];
   endfunction

endpackage

/* sv/sample_log_ring_with_timebase.sv */
// Sequence: a read of a live entry passes through the dispatch, read data and
// done states; any other read, a non-full store or an unused command through
// dispatch and done; a store into a full log or a clear also walks its n live
// entries (63, or up to 64) in the walk state, paced by the one memory read port.
// Throughput: one item at a time; the next may be accepted in the strobe cycle.
// Synchronous reset clears pointers, count, base; presets code; memories undefined.
// ---------------------------------------------------------------------------
// Sample log ring with timebase
// Ring log of typed readings in two memories, with a walked timestamp rebase.
// ---------------------------------------------------------------------------
module sample_log_ring_with_timebase
   import slrt_pkg::*;
#(
   parameter int BASE_SHIFT = BASE_SHIFT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_wdata
);

   // Entry memories.
   logic [7:0]  types_mem  [SLOTS];
   logic [31:0] values_mem [SLOTS];
   logic [7:0]  types_q;
   logic [31:0] values_q;

   // Memory port controls.
   logic              mem_rd_en;
   logic [SLOT_W-1:0] mem_rd_addr;
   logic              type_we;
   logic              val_we;
   logic [SLOT_W-1:0] mem_wr_addr;
   logic [7:0]        type_wdata;
   logic [31:0]       val_wdata;

   // Control and state registers.
   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [SLOT_W-1:0]  oldest_ff, oldest_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [31:0]        base_word_ff, base_word_in;
   logic [7:0]         ts_code_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   // Read result registers.
   logic        rd_valid_ff, rd_valid_in;
   logic [7:0]  rd_type_ff, rd_type_in;
   logic [31:0] rd_value_ff, rd_value_in;
   logic [63:0] rd_time_ff, rd_time_in;

   // Rebase walk registers.
   logic [COUNT_W-1:0] walk_count_ff, walk_count_in;
   logic [COUNT_W-1:0] issue_cnt_ff, issue_cnt_in;
   logic [SLOT_W-1:0]  walk_slot_ff, walk_slot_in;
   logic               p1_valid_ff, p1_valid_in;
   logic [SLOT_W-1:0]  p1_slot_ff, p1_slot_in;
   logic               p2_valid_ff, p2_valid_in;
   logic [SLOT_W-1:0]  p2_slot_ff, p2_slot_in;
   logic               p2_hit_ff, p2_hit_in;
   logic [63:0]        p2_t_ff, p2_t_in;
   logic               found_ff, found_in;
   logic [31:0]        newb_word_ff, newb_word_in;

   // Derived values.
   logic               accept;
   logic               walk_done;
   logic [63:0]        base_ms;
   logic [63:0]        values_sext;
   logic [31:0]        t_word;
   logic [31:0]        newb_eff_word;
   logic [31:0]        newb_low;
   logic [SLOT_W-1:0]  store_slot;
   logic [SLOT_W-1:0]  read_slot;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Shared arithmetic of the base and the walk.
   assign base_ms       = {32'd0, base_word_ff} << BASE_SHIFT;
   assign values_sext   = {{32{values_q[31]}}, values_q};
   assign t_word        = 32'(p2_t_ff >> BASE_SHIFT);
   assign newb_eff_word = found_ff ? newb_word_ff : t_word;
   assign newb_low      = 32'({32'd0, newb_eff_word} << BASE_SHIFT);
   assign store_slot    = slot_add(oldest_ff, count_ff[SLOT_W-1:0]);
   assign read_slot     = slot_add(oldest_ff, req_ff.read_index);
   assign walk_done     = (issue_cnt_ff == walk_count_ff) && !p1_valid_ff && !p2_valid_ff;

   // Entry memories: one write port each, one registered read port.
   always_ff @(posedge clock) begin
      if (type_we) begin
         types_mem[mem_wr_addr] <= type_wdata;
      end
      if (val_we) begin
         values_mem[mem_wr_addr] <= val_wdata;
      end
      if (mem_rd_en) begin
         types_q  <= types_mem[mem_rd_addr];
         values_q <= values_mem[mem_rd_addr];
      end
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (req_ff.command)
               CMD_STORE: begin
                  state_in = (count_ff >= COUNT_W'(SLOTS)) ? ST_WALK : ST_DONE;
               end
               CMD_CLEAR: state_in = ST_WALK;
               CMD_READ: begin
                  state_in = ({1'b0, req_ff.read_index} < count_ff) ? ST_READ_DATA
                                                                    : ST_DONE;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_READ_DATA: state_in = ST_DONE;
         ST_WALK: begin
            if (walk_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory controls for each state.
   always_comb begin
      req_in        = req_ff;
      oldest_in     = oldest_ff;
      count_in      = count_ff;
      base_word_in  = base_word_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      rd_valid_in   = rd_valid_ff;
      rd_type_in    = rd_type_ff;
      rd_value_in   = rd_value_ff;
      rd_time_in    = rd_time_ff;
      walk_count_in = walk_count_ff;
      issue_cnt_in  = issue_cnt_ff;
      walk_slot_in  = walk_slot_ff;
      p1_valid_in   = 1'b0;
      p1_slot_in    = p1_slot_ff;
      p2_valid_in   = 1'b0;
      p2_slot_in    = p2_slot_ff;
      p2_hit_in     = p2_hit_ff;
      p2_t_in       = p2_t_ff;
      found_in      = found_ff;
      newb_word_in  = newb_word_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = read_slot;
      type_we       = 1'b0;
      val_we        = 1'b0;
      mem_wr_addr   = store_slot;
      type_wdata    = req_ff.sensor_type;
      val_wdata     = req_ff.reading_value;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in = req_data;
            end
         end
         ST_DISPATCH: begin
            // Read fields are zero unless a read finds a live entry.
            rd_valid_in  = 1'b0;
            rd_type_in   = '0;
            rd_value_in  = '0;
            rd_time_in   = '0;
            issue_cnt_in = '0;
            found_in     = 1'b0;
            unique case (req_ff.command)
               CMD_STORE: begin
                  type_we = 1'b1;
                  val_we  = 1'b1;
                  if (count_ff >= COUNT_W'(SLOTS)) begin
                     // Full: drop the oldest entry and walk the rest.
                     oldest_in     = slot_add(oldest_ff, SLOT_W'(1));
                     walk_slot_in  = slot_add(oldest_ff, SLOT_W'(1));
                     walk_count_in = COUNT_W'(SLOTS - 1);
                  end else begin
                     count_in = count_ff + COUNT_W'(1);
                  end
               end
               CMD_CLEAR: begin
                  if (req_ff.clear_count >= count_ff) begin
                     oldest_in     = '0;
                     count_in      = '0;
                     walk_slot_in  = '0;
                     walk_count_in = '0;
                  end else begin
                     oldest_in     = slot_add(oldest_ff, req_ff.clear_count[SLOT_W-1:0]);
                     walk_slot_in  = slot_add(oldest_ff, req_ff.clear_count[SLOT_W-1:0]);
                     count_in      = count_ff - req_ff.clear_count;
                     walk_count_in = count_ff - req_ff.clear_count;
                  end
               end
               CMD_READ: begin
                  if ({1'b0, req_ff.read_index} < count_ff) begin
                     mem_rd_en   = 1'b1;
                     rd_valid_in = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_READ_DATA: begin
            rd_type_in  = types_q;
            rd_value_in = values_q;
            rd_time_in  = (types_q == ts_code_ff) ? (base_ms + values_sext) : 64'd0;
         end
         ST_WALK: begin
            // Issue one entry read a cycle.
            if (issue_cnt_ff != walk_count_ff) begin
               mem_rd_en    = 1'b1;
               mem_rd_addr  = walk_slot_ff;
               walk_slot_in = slot_add(walk_slot_ff, SLOT_W'(1));
               issue_cnt_in = issue_cnt_ff + COUNT_W'(1);
               p1_valid_in  = 1'b1;
               p1_slot_in   = walk_slot_ff;
            end
            // Form the absolute time of the entry just read.
            if (p1_valid_ff) begin
               p2_valid_in = 1'b1;
               p2_slot_in  = p1_slot_ff;
               p2_hit_in   = (types_q == ts_code_ff);
               p2_t_in     = base_ms + values_sext;
            end
            // Rewrite a timestamp against the new base; the first one sets it.
            if (p2_valid_ff && p2_hit_ff) begin
               val_we       = 1'b1;
               mem_wr_addr  = p2_slot_ff;
               val_wdata    = p2_t_ff[31:0] - newb_low;
               found_in     = 1'b1;
               newb_word_in = newb_eff_word;
            end
            if (walk_done) begin
               base_word_in = found_ff ? newb_word_ff : 32'(req_ff.now_ms >> BASE_SHIFT);
            end
         end
         ST_DONE: begin
            rsp_valid_in         = 1'b1;
            rsp_in.entry_count   = count_ff;
            rsp_in.oldest_slot   = oldest_ff;
            rsp_in.base_ms       = base_ms;
            rsp_in.read_valid    = rd_valid_ff;
            rsp_in.read_type     = rd_type_ff;
            rsp_in.read_value    = rd_value_ff;
            rsp_in.read_time_ms  = rd_time_ff;
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         oldest_ff    <= '0;
         count_ff     <= '0;
         base_word_ff <= '0;
         ts_code_ff   <= TS_CODE_RESET;
         rsp_valid_ff <= 1'b0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         base_word_ff <= base_word_in;
         rsp_valid_ff <= rsp_valid_in;
         p1_valid_ff  <= p1_valid_in;
         p2_valid_ff  <= p2_valid_in;
         found_ff     <= found_in;
         if (csr_valid && csr_ready) begin
            ts_code_ff <= csr_wdata;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      rsp_ff        <= rsp_in;
      rd_valid_ff   <= rd_valid_in;
      rd_type_ff    <= rd_type_in;
      rd_value_ff   <= rd_value_in;
      rd_time_ff    <= rd_time_in;
      walk_count_ff <= walk_count_in;
      issue_cnt_ff  <= issue_cnt_in;
      walk_slot_ff  <= walk_slot_in;
      p1_slot_ff    <= p1_slot_in;
      p2_slot_ff    <= p2_slot_in;
      p2_hit_ff     <= p2_hit_in;
      p2_t_ff       <= p2_t_in;
      newb_word_ff  <= newb_word_in;
   end

endmodule

/* sv/slrt_checker.sv */
// ---------------------------------------------------------------------------
// Sample log ring checker
// Port-level checks on the sequencing and results of the sample log ring.
// ---------------------------------------------------------------------------
`include "sample_log_ring_with_timebase_defines.svh"

module slrt_checker
   import slrt_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input rsp_type     rsp_data
);

   // An accepted item keeps the block busy in the following cycle.
   `SLRT_ASSERT_NEXT(busy_after_accept, clock, reset, start && !busy, busy)

   // A result is only strobed once the block is free again.
   `SLRT_ASSERT_SAME(result_when_free, clock, reset, rsp_valid, !busy)

   // Every item passes through dispatch before its done state, so strobes never touch.
   `SLRT_ASSERT_NEXT(single_strobe, clock, reset, rsp_valid, !rsp_valid)

   // The reported count never exceeds the ring size.
   `SLRT_ASSERT_SAME(count_in_range, clock, reset, rsp_valid,
                     rsp_data.entry_count <= COUNT_W'(SLOTS))

   // Read fields are zero when no live entry was read.
   `SLRT_ASSERT_SAME(read_fields_idle, clock, reset, rsp_valid && !rsp_data.read_valid,
                     rsp_data.read_type == 8'd0 && rsp_data.read_value == 32'sd0 &&
                     rsp_data.read_time_ms == 64'd0)

endmodule

bind sample_log_ring_with_timebase slrt_checker u_slrt_checker (.*);

/* tb/testbench.sv */
// ---------------------------------------------------------------------------
// Sample log ring with timebase testbench
// Drives store, clear and read items into the log ring through its command
// port, and writes the timestamp type code between phases while the block is
// idle. A local model of the ring, its timestamp rebase walk and the shared
// base predicts the status of every item. The monitor checks each strobed
// status field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module testbench;
   import slrt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int BASE_SHIFT = BASE_SHIFT_DEFAULT;

   // Command code that the block does not decode.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Items per random phase, one timestamp code per phase.
   localparam int PHASE_ITEMS = 145;
   localparam int PHASES      = 6;

   // One queued job: an item for the command port or a code register write.
   typedef struct {
      bit         is_write;
      req_type    item;
      logic [7:0] code;
   } job_type;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       start     = 1'b0;
   logic       busy;
   req_type    req_data  = '0;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_wdata = '0;

   job_type    job_q[$];
   rsp_type    log_status_q[$];
   int         error_count = 0;
   int         in_flight   = 0;
   int         items_sent  = 0;
   logic [63:0] elapsed_ms = '0;

   // Model of the ring: entry memories, pointers, base and code register.
   logic [7:0]  slot_type[SLOTS];
   logic [31:0] slot_value[SLOTS];
   int          oldest_pos   = 0;
   int          live_entries = 0;
   logic [31:0] base_hi      = '0;
   logic [7:0]  stamp_code   = TS_CODE_RESET;

   sample_log_ring_with_timebase #(
      .BASE_SHIFT (BASE_SHIFT)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // Rewrite the timestamp offsets of the first walk live entries against a
   // new base, taken from the first timestamp found or else from now_val.
   task automatic rebase_log(input int walk, input logic [63:0] now_val);
      logic [63:0] keep_mask;
      logic [63:0] old_base;
      logic [63:0] new_base;
      logic [63:0] abs_ms;
      bit          found;
      int          s;
      keep_mask = ~((64'd1 << BASE_SHIFT) - 64'd1);
      old_base  = {32'd0, base_hi} << BASE_SHIFT;
      new_base  = '0;
      found     = 1'b0;
      for (int i = 0; i < walk; i++) begin
         s = (oldest_pos + i) % SLOTS;
         if (slot_type[s] == stamp_code) begin
            abs_ms = old_base + {{32{slot_value[s][31]}}, slot_value[s]};
            if (!found) begin
               new_base = abs_ms & keep_mask;
               found    = 1'b1;
            end
            slot_value[s] = abs_ms[31:0] - new_base[31:0];
         end
      end
      if (!found) begin
         new_base = now_val & keep_mask;
      end
      base_hi = 32'(new_base >> BASE_SHIFT);
   endtask

   // Apply one accepted item to the ring model and work out its status.
   task automatic apply_log_command(input req_type cmd_item, output rsp_type status);
      int s;
      status = '0;
      case (cmd_item.command)
         CMD_STORE: begin
            s = (oldest_pos + live_entries) % SLOTS;
            if (live_entries >= SLOTS) begin
               // The dropped oldest entry takes no part in the walk.
               oldest_pos = (oldest_pos + 1) % SLOTS;
               rebase_log(SLOTS - 1, cmd_item.now_ms);
            end else begin
               live_entries++;
            end
            slot_type[s]  = cmd_item.sensor_type;
            slot_value[s] = cmd_item.reading_value;
         end
         CMD_CLEAR: begin
            if (int'(cmd_item.clear_count) >= live_entries) begin
               oldest_pos   = 0;
               live_entries = 0;
            end else begin
               oldest_pos   = (oldest_pos + int'(cmd_item.clear_count)) % SLOTS;
               live_entries = live_entries - int'(cmd_item.clear_count);
            end
            rebase_log(live_entries, cmd_item.now_ms);
         end
         CMD_READ: begin
            if (int'(cmd_item.read_index) < live_entries) begin
               s = (oldest_pos + int'(cmd_item.read_index)) % SLOTS;
               status.read_valid = 1'b1;
               status.read_type  = slot_type[s];
               status.read_value = slot_value[s];
               if (slot_type[s] == stamp_code) begin
                  status.read_time_ms = ({32'd0, base_hi} << BASE_SHIFT)
                                      + {{32{slot_value[s][31]}}, slot_value[s]};
               end
            end
         end
         default: begin
         end
      endcase
      status.entry_count = 7'(live_entries);
      status.oldest_slot = 6'(oldest_pos);
      status.base_ms     = {32'd0, base_hi} << BASE_SHIFT;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Uptime mostly advances steadily, with the odd wild value.
   function automatic logic [63:0] next_now();
      elapsed_ms = elapsed_ms + 64'($urandom_range(0, 3000));
      if ($urandom_range(0, 19) == 0) begin
         return rand64();
      end
      return elapsed_ms;
   endfunction

   // Timestamp entries are common so that the rebase walk has work to do.
   function automatic logic [7:0] pick_type(input logic [7:0] code);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return code;
         4:          return code ^ 8'h01;
         default:    return 8'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2: return 32'($urandom_range(0, 262143));
         3, 4:    return 32'd0 - 32'($urandom_range(1, 262143));
         5: begin
            case ($urandom_range(0, 3))
               0:       return 32'h8000_0000;
               1:       return 32'h7FFF_FFFF;
               2:       return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_item(input logic [1:0] cmd, input logic [7:0] stype,
                             input logic [31:0] val, input logic [6:0] cnt,
                             input logic [5:0] idx, input logic [63:0] now_val);
      job_type j;
      j.is_write            = 1'b0;
      j.code                = '0;
      j.item.command        = cmd;
      j.item.sensor_type    = stype;
      j.item.reading_value  = val;
      j.item.clear_count    = cnt;
      j.item.read_index     = idx;
      j.item.now_ms         = now_val;
      job_q.push_back(j);
   endtask

   task automatic queue_code(input logic [7:0] code);
      job_type j;
      j.is_write = 1'b1;
      j.item     = '0;
      j.code     = code;
      job_q.push_back(j);
   endtask

   // Driver: items and code writes are taken from the job queue. A code write
   // waits until every item in flight has returned its status.
   always @(posedge clock) begin : drive_proc
      logic    item_taken;
      logic    write_taken;
      logic    next_start;
      logic    next_write;
      logic    quiet;
      req_type next_item;
      logic [7:0] next_wdata;
      rsp_type status;
      job_type j;
      if (reset) begin
         start     <= 1'b0;
         csr_valid <= 1'b0;
         in_flight = 0;
      end else begin
         item_taken  = start && !busy;
         write_taken = csr_valid && csr_ready;
         if (item_taken) begin
            apply_log_command(req_data, status);
            log_status_q.push_back(status);
            in_flight++;
            items_sent++;
         end
         if (rsp_valid) begin
            in_flight--;
         end
         if (write_taken) begin
            stamp_code = csr_wdata;
         end
         next_start = start && !item_taken;
         next_write = csr_valid && !write_taken;
         next_item  = req_data;
         next_wdata = csr_wdata;
         quiet      = (items_sent >= 400) && (items_sent < 560);
         if (!next_start && !next_write && job_q.size() != 0) begin
            if (!quiet && $urandom_range(0, 99) < 11) begin
               // Idle this cycle.
            end else if (!job_q[0].is_write) begin
               j          = job_q.pop_front();
               next_item  = j.item;
               next_start = 1'b1;
            end else if (in_flight == 0) begin
               j          = job_q.pop_front();
               next_wdata = j.code;
               next_write = 1'b1;
            end
         end
         start     <= next_start;
         req_data  <= next_item;
         csr_valid <= next_write;
         csr_wdata <= next_wdata;
      end
   end

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h got %h", $time, name, want, got);
         error_count++;
      end
   endfunction

   // Monitor: every strobed status is matched against the oldest prediction.
   always @(posedge clock) begin : watch_proc
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (log_status_q.size() == 0) begin
            $display("%0t: status with none expected, got %h", $time, rsp_data);
            error_count++;
         end else begin
            want = log_status_q.pop_front();
            check_field("entry_count",  64'(want.entry_count),  64'(rsp_data.entry_count));
            check_field("oldest_slot",  64'(want.oldest_slot),  64'(rsp_data.oldest_slot));
            check_field("base_ms",      want.base_ms,           rsp_data.base_ms);
            check_field("read_valid",   64'(want.read_valid),   64'(rsp_data.read_valid));
            check_field("read_type",    64'(want.read_type),    64'(rsp_data.read_type));
            check_field("read_value",   {32'd0, want.read_value},
                        {32'd0, rsp_data.read_value});
            check_field("read_time_ms", want.read_time_ms,      rsp_data.read_time_ms);
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      logic [7:0] code;
      int         pick;
      int         store_pct;
      logic [6:0] cnt;
      for (int i = 0; i < SLOTS; i++) begin
         slot_type[i]  = '0;
         slot_value[i] = '0;
      end

      // Directed: extreme values under the reset timestamp code.
      queue_item(CMD_STORE, TS_CODE_RESET, 32'h7FFF_FFFF, 7'd0, 6'd0, 64'd0);
      queue_item(CMD_STORE, 8'd0, 32'h8000_0000, 7'd127, 6'd63, 64'd0);
      queue_item(CMD_STORE, 8'd255, 32'hFFFF_FFFF, 7'd0, 6'd0, 64'd1);
      queue_item(CMD_STORE, TS_CODE_RESET, 32'h8000_0000, 7'd0, 6'd0, 64'd2);
      queue_item(CMD_READ, 8'd0, 32'd0, 7'd0, 6'd0, 64'd3);
      queue_item(CMD_READ, 8'hFF, 32'hFFFF_FFFF, 7'd127, 6'd3, 64'd3);
      queue_item(CMD_READ, 8'd0, 32'd0, 7'd0, 6'd2, 64'd3);
      // An unused command changes nothing and reports no read.
      queue_item(CMD_UNUSED, 8'd9, 32'd9, 7'd1, 6'd0, 64'd4);
      // A clear of nothing still rebases.
      queue_item(CMD_CLEAR, 8'd0, 32'd0, 7'd0, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_item(CMD_READ, 8'd0, 32'd0, 7'd0, 6'd0, 64'd5);

      // Fill the log so that every slot has been written, then overflow it.
      for (int i = 4; i < SLOTS; i++) begin
         queue_item(CMD_STORE, (i % 5 == 0) ? TS_CODE_RESET : 8'(i),
                    32'(i * 1000), 7'd0, 6'd0, 64'(i * 70000));
      end
      queue_item(CMD_STORE, TS_CODE_RESET, 32'h0001_2345, 7'd0, 6'd0,
                 64'hFFFF_FFFF_FFFF_FFFF);
      queue_item(CMD_STORE, 8'd1, 32'h5555_AAAA, 7'd0, 6'd0, 64'h8000_0000_0000_0000);
      queue_item(CMD_READ, 8'd0, 32'd0, 7'd0, 6'd63, 64'd0);
      queue_item(CMD_READ, 8'd0, 32'd0, 7'd0, 6'd0, 64'd0);

      // Partial clear, a read past the live entries, then a clear of all.
      queue_item(CMD_CLEAR, 8'd0, 32'd0, 7'd3, 6'd0, 64'd1000);
      queue_item(CMD_READ, 8'd0, 32'd0, 7'd0, 6'd63, 64'd0);
      queue_item(CMD_CLEAR, 8'd0, 32'd0, 7'd127, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_item(CMD_READ, 8'd0, 32'd0, 7'd0, 6'd0, 64'd0);

      // A first timestamp at absolute time zero still defines the base.
      queue_item(CMD_CLEAR, 8'd0, 32'd0, 7'd64, 6'd0, 64'd1234);
      queue_item(CMD_STORE, TS_CODE_RESET, 32'd0, 7'd0, 6'd0, 64'd0);
      queue_item(CMD_STORE, TS_CODE_RESET, 32'd5, 7'd0, 6'd0, 64'd0);
      queue_item(CMD_STORE, 8'd3, 32'd77, 7'd0, 6'd0, 64'd0);
      queue_item(CMD_CLEAR, 8'd0, 32'd0, 7'd0, 6'd0, 64'h0123_4567_89AB_CDEF);
      queue_item(CMD_READ, 8'd0, 32'd0, 7'd0, 6'd1, 64'd0);
      // A clear of exactly the live count empties the log.
      queue_item(CMD_CLEAR, 8'd0, 32'd0, 7'd3, 6'd0, 64'd99999);

      // Random phases, each under its own timestamp code.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       code = 8'd0;
            1:       code = 8'd255;
            2:       code = TS_CODE_RESET;
            4:       code = 8'd1;
            default: code = 8'($urandom_range(2, 254));
         endcase
         queue_code(code);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick      = $urandom_range(0, 99);
            store_pct = (n < PHASE_ITEMS / 2) ? 72 : 45;
            if (pick < store_pct) begin
               queue_item(CMD_STORE, pick_type(code), pick_value(),
                          7'($urandom), 6'($urandom), next_now());
            end else if (pick < store_pct + 27 - (n < PHASE_ITEMS / 2 ? 7 : 0)) begin
               queue_item(CMD_READ, 8'($urandom), $urandom, 7'($urandom),
                          6'($urandom_range(0, 63)), next_now());
            end else if (pick < 97) begin
               case ($urandom_range(0, 9))
                  8:       cnt = 7'($urandom_range(7, 63));
                  9:       cnt = 7'($urandom_range(64, 127));
                  default: cnt = 7'($urandom_range(0, 6));
               endcase
               queue_item(CMD_CLEAR, 8'($urandom), $urandom, cnt, 6'($urandom),
                          next_now());
            end else begin
               queue_item(CMD_UNUSED, 8'($urandom), $urandom, 7'($urandom),
                          6'($urandom), next_now());
            end
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Sample between edges so that the driver's updates are settled.
      while (job_q.size() != 0 || start || csr_valid) begin
         @(negedge clock);
      end
      while (log_status_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (80) @(posedge clock);
      if (error_count == 0) begin
         $display("[sample_log_ring_with_timebase] OK");
      end else begin
         $display("[sample_log_ring_with_timebase] ERROR");
      end
      $finish;
   end

   // Watchdog for a hung block.
   initial begin
      #(5_000_000);
      $display("[sample_log_ring_with_timebase] ERROR");
      $finish;
   end

endmodule

/* sim.f */
+incdir+sv
sv/slrt_pkg.sv
sv/sample_log_ring_with_timebase.sv
sv/slrt_checker.sv
tb/testbench.sv
